// File: hdl/kts_pkg.sv
// Shared types and constants for the keyword token scanner.
package kts_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_HALT   = 2'd3
    } scan_mode_t;

    localparam int NUM_KEYWORDS = 6;
    localparam int NUM_OPS      = 10;
    localparam int KW_MAX_CHARS = 8;

    localparam logic [4:0] KIND_END      = 5'd0;
    localparam logic [4:0] KIND_IDENT    = 5'd1;
    localparam logic [4:0] KIND_NUMBER   = 5'd2;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd3;
    localparam logic [4:0] KIND_OP0      = 5'd9;
    localparam logic [4:0] KIND_ERROR    = 5'd19;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;

    // keyword spellings, padded with NUL
    localparam logic [7:0] KW_CHARS [NUM_KEYWORDS][KW_MAX_CHARS] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h65, 8'h67, 8'h65, 8'h72, 8'h00}, // integer
        '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00}, // float
        '{8'h74, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // te
        '{8'h64, 8'h65, 8'h6B, 8'h68, 8'h61, 8'h6F, 8'h00, 8'h00}, // dekhao
        '{8'h6A, 8'h6F, 8'h64, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00}, // jodi
        '{8'h6E, 8'h61, 8'h68, 8'h6F, 8'h6C, 8'h65, 8'h00, 8'h00}  // nahole
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{4'd7, 4'd5, 4'd2, 4'd6, 4'd4, 4'd6};

    // + - * / ( ) { } > =
    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3E, 8'h3D
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        saturated;
        logic        last;
    } token_t;

endpackage

// File: hdl/keyword_token_scanner_unit.sv
// Streaming lexical scanner: one source byte in, up to two tokens out.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  text    | text_valid text_ready text_byte           | in
//          | end_of_text                               |
//  token   | token_valid token_ready token_kind        | out
//          | token_start token_length length_saturated |
//          | last_of_run                               |
//
// Flow: a byte is classified and the scan state advanced in the cycle it is
// accepted; its tokens are written into a four-word output queue and appear
// on the token port from the next cycle on, one word per cycle while token_ready
// is high. One byte per clock is sustained while each byte yields at most one
// token and tokens drain; a byte that closes a token and opens an operator or END
// pushes two words. Reset clears the scan state, the offset counter and the queue
// at once. Stalls: text_ready drops when fewer than two queue slots are free.
module keyword_token_scanner_unit #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                text_valid,
    output logic                text_ready,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,

    output logic                token_valid,
    input  logic                token_ready,
    output logic [4:0]          token_kind,
    output logic [31:0]         token_start,
    output logic [15:0]         token_length,
    output logic                length_saturated,
    output logic                last_of_run
);
    import kts_pkg::*;

    localparam int PLEN_BITS   = LENGTH_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    scan_mode_t                 mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]     offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]     pstart_reg, pstart_next;
    logic [PLEN_BITS-1:0]       plen_reg, plen_next;
    logic [NUM_KEYWORDS-1:0]    alive_reg, alive_next;

    // Output queue
    token_t                     queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]       count_reg, count_next;

    logic                       accept;
    logic                       pop;
    logic                       at_end;
    logic                       is_letter, is_digit, is_space, is_op;
    logic                       ident_char, number_char;
    logic                       extend, flush;
    logic [4:0]                 op_kind;
    logic [4:0]                 flush_kind;
    logic [NUM_KEYWORDS-1:0]    alive_extend, alive_start;
    logic [PLEN_BITS-1:0]       plen_inc;
    token_t                     res0, res1;
    logic [1:0]                 res_count;

    // Reported length: saturate to LENGTH_BITS, then fit into 16 bits.
    function automatic logic [15:0] fit_length(input logic [PLEN_BITS-1:0] len);
        logic [LENGTH_BITS-1:0]    sat_len;
        logic [LENGTH_BITS+15:0]   wide;
        sat_len = len[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : len[LENGTH_BITS-1:0];
        wide    = {16'b0, sat_len};
        return wide[15:0];
    endfunction

    function automatic logic [31:0] fit_offset(input logic [OFFSET_BITS-1:0] off);
        logic [OFFSET_BITS+31:0] wide;
        wide = {32'b0, off};
        return wide[31:0];
    endfunction

    function automatic token_t make_token(input logic [4:0] kind,
                                          input logic [OFFSET_BITS-1:0] start,
                                          input logic [PLEN_BITS-1:0] len);
        token_t t;
        t.kind      = kind;
        t.start     = fit_offset(start);
        t.length    = fit_length(len);
        t.saturated = len[LENGTH_BITS];
        t.last      = 1'b0;
        return t;
    endfunction

    assign accept = text_valid && text_ready;
    assign pop    = token_valid && token_ready;

    // ------------------------------------------------------------------
    // Byte classification
    // ------------------------------------------------------------------
    always_comb
    begin
        at_end    = end_of_text || (text_byte == CH_NUL);
        is_letter = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_digit  = text_byte inside {[8'h30:8'h39]};
        is_space  = text_byte inside {8'h20, [8'h09:8'h0D]};
        is_op     = 1'b0;
        op_kind   = KIND_ERROR;
        for (int k = 0; k < NUM_OPS; k++)
        begin
            if (text_byte == OP_CHARS[k])
            begin
                is_op   = 1'b1;
                op_kind = KIND_OP0 + 5'(k);
            end
        end
        ident_char  = is_letter || is_digit || (text_byte == CH_UNDERSCORE);
        number_char = is_digit || (text_byte == CH_DOT);
    end

    // ------------------------------------------------------------------
    // Keyword candidates: drop each keyword whose next character disagrees
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            if (plen_reg >= PLEN_BITS'(KW_LEN[k]))
                alive_extend[k] = 1'b0;
            else
                alive_extend[k] = alive_reg[k] && (KW_CHARS[k][plen_reg[2:0]] == text_byte);
            alive_start[k] = (KW_CHARS[k][0] == text_byte);
        end
    end

    // Hold the length once it passes the field's maximum.
    assign plen_inc = plen_reg[LENGTH_BITS] ? plen_reg : plen_reg + PLEN_BITS'(1);

    // Kind of the pending token when it closes
    always_comb
    begin
        flush_kind = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        if (mode_reg == MODE_IDENT)
        begin
            for (int k = 0; k < NUM_KEYWORDS; k++)
            begin
                if (alive_reg[k] && (plen_reg == PLEN_BITS'(KW_LEN[k])))
                    flush_kind = KIND_KEYWORD0 + 5'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan step: next state and up to two result words
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        alive_next  = alive_reg;
        res0        = '0;
        res1        = '0;
        res_count   = 2'd0;

        extend = ((mode_reg == MODE_IDENT) && !at_end && ident_char) ||
                 ((mode_reg == MODE_NUMBER) && !at_end && number_char);
        flush  = ((mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER)) && !extend;

        if (extend)
        begin
            // grow the open token
            plen_next   = plen_inc;
            if (mode_reg == MODE_IDENT)
                alive_next = alive_extend;
            offset_next = offset_reg + OFFSET_BITS'(1);
        end
        else
        begin
            if (flush)
            begin
                res0      = make_token(flush_kind, pstart_reg, plen_reg);
                res_count = 2'd1;
                mode_next = MODE_IDLE;
                plen_next = '0;
                alive_next = '1;
            end

            if (at_end)
            begin
                // emit END and start over for the next text
                if (res_count == 2'd0)
                    res0 = make_token(KIND_END, offset_reg, '0);
                else
                    res1 = make_token(KIND_END, offset_reg, '0);
                res_count   = res_count + 2'd1;
                mode_next   = MODE_IDLE;
                offset_next = '0;
                pstart_next = '0;
                plen_next   = '0;
                alive_next  = '1;
            end
            else
            begin
                offset_next = offset_reg + OFFSET_BITS'(1);
                if ((mode_reg == MODE_HALT) || is_space)
                begin
                    // drop the byte
                end
                else if (ident_char)
                begin
                    mode_next   = is_digit ? MODE_NUMBER : MODE_IDENT;
                    pstart_next = offset_reg;
                    plen_next   = PLEN_BITS'(1);
                    alive_next  = is_digit ? '1 : alive_start;
                end
                else
                begin
                    if (res_count == 2'd0)
                        res0 = make_token(op_kind, offset_reg, PLEN_BITS'(1));
                    else
                        res1 = make_token(op_kind, offset_reg, PLEN_BITS'(1));
                    res_count = res_count + 2'd1;
                    if (!is_op)
                        mode_next = MODE_HALT;
                end
            end
        end

        // mark the final word of this byte
        if (res_count == 2'd1)
            res0.last = 1'b1;
        if (res_count == 2'd2)
            res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            alive_reg  <= '1;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            alive_reg  <= alive_next;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: advance write pointer by the number of words pushed
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_BITS'(res_count);
            count_next  = count_next + QCNT_BITS'(res_count);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_BITS'(1);
            count_next  = count_next - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (res_count != 2'd0))
            queue_reg[wr_ptr_reg] <= res0;
        if (accept && (res_count == 2'd2))
            queue_reg[wr_ptr_reg + QPTR_BITS'(1)] <= res1;
    end

    // take a byte only with room for two words
    assign text_ready       = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign token_valid      = (count_reg != '0);
    assign token_kind       = queue_reg[rd_ptr_reg].kind;
    assign token_start      = queue_reg[rd_ptr_reg].start;
    assign token_length     = queue_reg[rd_ptr_reg].length;
    assign length_saturated = queue_reg[rd_ptr_reg].saturated;
    assign last_of_run      = queue_reg[rd_ptr_reg].last;

endmodule

// File: sim/tb.sv
// Testbench for keyword_token_scanner_unit: directed and random byte streams checked against a scan predictor.
`timescale 1ns / 1ps

module tb;
    import kts_pkg::*;

    localparam logic [16:0] LEN_CAP = 17'd65535;

    // One row of the opening text. Where fixed is set, the token is typed in
    // by hand and replaces whatever the predictor would have queued.
    typedef struct packed {
        logic [7:0]  ch;
        logic        eot;
        logic        fixed;
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
    } text_row_t;

    localparam int OPENING_ROWS = 25;
    localparam text_row_t OPENING_TEXT [OPENING_ROWS] = '{
        '{8'h2B, 1'b0, 1'b1, KIND_OP0,              32'd0,  16'd1}, // '+' right after reset
        '{8'h74, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 't'
        '{8'h65, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'e'
        '{8'h20, 1'b0, 1'b1, KIND_KEYWORD0 + 5'd2,  32'd1,  16'd2}, // space closes "te"
        '{8'h39, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // '9'
        '{8'h2E, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // '.'
        '{8'h3D, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // '=' closes number
        '{8'h5F, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // '_'
        '{8'h5A, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'Z'
        '{8'hFF, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // ident then error
        '{8'h61, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // ignored while halted
        '{8'h71, 1'b1, 1'b1, KIND_END,              32'd11, 16'd0}, // end marker
        '{8'h7D, 1'b0, 1'b1, KIND_OP0 + 5'd7,       32'd0,  16'd1}, // '}' at offset zero
        '{8'h00, 1'b0, 1'b1, KIND_END,              32'd1,  16'd0}, // zero byte ends text
        '{8'h09, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // tab
        '{8'h7A, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'z'
        '{8'h41, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'A'
        '{8'h0D, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // CR closes ident
        '{8'h30, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // '0'
        '{8'h6A, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'j' closes number
        '{8'h6F, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'o'
        '{8'h64, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'd'
        '{8'h69, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // 'i'
        '{8'h80, 1'b0, 1'b0, KIND_END,              32'd0,  16'd0}, // "jodi" then error
        '{8'hFF, 1'b1, 1'b1, KIND_END,              32'd10, 16'd0}  // end marker, byte ignored
    };

    logic        clk;
    logic        rst_n;
    logic        text_valid;
    logic        text_ready;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        token_valid;
    logic        token_ready;
    logic [4:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        length_saturated;
    logic        last_of_run;

    // predictor state
    scan_mode_t  mode_q;
    logic [31:0] offset_q;
    logic [31:0] open_start_q;
    logic [16:0] open_len_q;
    logic [5:0]  alive_q;

    token_t      tokens_due [$];
    int          fail_count;
    int          words_sent;
    int          tokens_checked;
    int          texts_closed;
    int          saturated_seen;
    bit          calm;

    keyword_token_scanner_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .text_valid       (text_valid),
        .text_ready       (text_ready),
        .text_byte        (text_byte),
        .end_of_text      (end_of_text),
        .token_valid      (token_valid),
        .token_ready      (token_ready),
        .token_kind       (token_kind),
        .token_start      (token_start),
        .token_length     (token_length),
        .length_saturated (length_saturated),
        .last_of_run      (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Character classes
    // ---------------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_letter(c) || is_decimal(c) || c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_operator(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < NUM_OPS; k++)
            if (OP_CHARS[k] == c)
                hit = 1'b1;
        return hit;
    endfunction

    // ---------------------------------------------------------------------
    // Scan predictor
    // ---------------------------------------------------------------------
    function automatic token_t make_token(input logic [4:0] kind, input logic [31:0] start,
                                          input logic [16:0] len);
        token_t t;
        t.kind      = kind;
        t.start     = start;
        t.length    = (len > LEN_CAP) ? LEN_CAP[15:0] : len[15:0];
        t.saturated = len > LEN_CAP;
        t.last      = 1'b0;
        return t;
    endfunction

    function automatic void clear_scan();
        mode_q       = MODE_IDLE;
        offset_q     = '0;
        open_start_q = '0;
        open_len_q   = '0;
        alive_q      = '1;
    endfunction

    // Extend the open token by one byte; drop keyword candidates that disagree.
    function automatic void grow_open(input logic [7:0] c);
        if (mode_q == MODE_IDENT)
        begin
            for (int k = 0; k < NUM_KEYWORDS; k++)
            begin
                if (open_len_q >= 17'(KW_LEN[k]))
                    alive_q[k] = 1'b0;
                else if (KW_CHARS[k][open_len_q[2:0]] != c)
                    alive_q[k] = 1'b0;
            end
        end
        if (open_len_q <= LEN_CAP)
            open_len_q = open_len_q + 17'd1;
    endfunction

    function automatic void close_open();
        logic [4:0] kind;
        kind = KIND_NUMBER;
        if (mode_q == MODE_IDENT)
        begin
            kind = KIND_IDENT;
            for (int k = 0; k < NUM_KEYWORDS; k++)
                if (alive_q[k] && open_len_q == 17'(KW_LEN[k]))
                    kind = KIND_KEYWORD0 + 5'(k);
        end
        tokens_due.push_back(make_token(kind, open_start_q, open_len_q));
        mode_q     = MODE_IDLE;
        open_len_q = '0;
        alive_q    = '1;
    endfunction

    // Advance the predictor by one accepted word; queue its tokens, return how many.
    function automatic int scan_expect(input logic [7:0] c, input logic eot);
        logic       at_end;
        bit         absorbed;
        int         n;
        logic [4:0] kind;
        token_t     tail;
        at_end   = eot || (c == CH_NUL);
        absorbed = 1'b0;
        n        = 0;
        if (mode_q == MODE_IDENT || mode_q == MODE_NUMBER)
        begin
            if (!at_end && ((mode_q == MODE_IDENT) ? is_word_char(c)
                                                   : (is_decimal(c) || c == CH_DOT)))
            begin
                grow_open(c);
                absorbed = 1'b1;
            end
            else
            begin
                close_open();
                n++;
            end
        end
        if (!absorbed)
        begin
            if (at_end)
            begin
                tokens_due.push_back(make_token(KIND_END, offset_q, 17'd0));
                n++;
                texts_closed++;
            end
            else if (mode_q == MODE_HALT || is_blank(c))
            begin
                // skip
            end
            else if (is_word_char(c))
            begin
                mode_q       = is_decimal(c) ? MODE_NUMBER : MODE_IDENT;
                open_start_q = offset_q;
                open_len_q   = '0;
                alive_q      = '1;
                grow_open(c);
            end
            else
            begin
                kind = KIND_ERROR;
                for (int k = 0; k < NUM_OPS; k++)
                    if (OP_CHARS[k] == c)
                        kind = KIND_OP0 + 5'(k);
                tokens_due.push_back(make_token(kind, offset_q, 17'd1));
                n++;
                if (kind == KIND_ERROR)
                    mode_q = MODE_HALT;
            end
        end
        // end of text returns everything, the offset too, to its reset value
        if (at_end)
            clear_scan();
        else
            offset_q = offset_q + 32'd1;
        if (n > 0)
        begin
            tail = tokens_due.pop_back();
            tail.last = 1'b1;
            tokens_due.push_back(tail);
        end
        return n;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_word_char(input bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
            return 8'h61 + 8'(r);
        else if (r < 52)
            return 8'h41 + 8'(r - 26);
        else if (r == 52)
            return CH_UNDERSCORE;
        else
            return 8'h30 + 8'(r - 53);
    endfunction

    function automatic logic [7:0] pick_number_char();
        return ($urandom_range(0, 4) == 0) ? CH_DOT : 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    // A byte of no class at all: not blank, word, operator or zero.
    function automatic logic [7:0] pick_stray_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_word_char(b) || is_blank(b) || is_operator(b));
        return b;
    endfunction

    // Offer one word on the text channel and hold it until accepted. Called at a
    // falling edge; returns at the falling edge after acceptance.
    task automatic put_word(input logic [7:0] b, input logic eot, input bit fixed,
                            input token_t fixed_tok);
        int gap;
        int n;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            text_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_byte   = b;
        end_of_text = eot;
        text_valid  = 1'b1;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        n = scan_expect(b, eot);
        if (fixed)
        begin
            // swap the predicted token for the hand-typed one
            repeat (n) void'(tokens_due.pop_back());
            tokens_due.push_back(fixed_tok);
        end
        words_sent++;
        @(negedge clk);
    endtask

    task automatic put_text(input logic [7:0] b, input logic eot);
        put_word(b, eot, 1'b0, '0);
    endtask

    // Drop valid and hold off until every queued token has come out.
    task automatic drain_tokens();
        text_valid = 1'b0;
        @(negedge clk);
        while (tokens_due.size() != 0)
            @(negedge clk);
    endtask

    // Send one lexeme: mostly well-formed tokens with random content, some noise.
    task automatic send_lexeme();
        int   pick;
        int   k;
        int   len;
        bit   stretch;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, NUM_KEYWORDS - 1);
        if (pick < 22)
        begin
            for (int i = 0; i < KW_LEN[k]; i++)
                put_text(KW_CHARS[k][i], 1'b0);
        end
        else if (pick < 32)
        begin
            // keyword one short, or one too long
            stretch = 1'($urandom_range(0, 1));
            len = stretch ? KW_LEN[k] : KW_LEN[k] - 1;
            for (int i = 0; i < len; i++)
                put_text(KW_CHARS[k][i], 1'b0);
            if (stretch)
                put_text(pick_word_char(1'b0), 1'b0);
        end
        else if (pick < 50)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                put_text(pick_word_char(i == 0), 1'b0);
        end
        else if (pick < 62)
        begin
            len = $urandom_range(1, 8);
            put_text(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
            for (int i = 1; i < len; i++)
                put_text(pick_number_char(), 1'b0);
        end
        else if (pick < 75)
            put_text(OP_CHARS[$urandom_range(0, NUM_OPS - 1)], 1'b0);
        else if (pick < 85)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                put_text(($urandom_range(0, 1) == 0) ? 8'h20 : 8'(8 + $urandom_range(1, 5)),
                         1'b0);
        end
        else if (pick < 91)
        begin
            // end marker with a random byte, or a plain zero byte
            if ($urandom_range(0, 1) == 0)
                put_text(8'($urandom_range(0, 255)), 1'b1);
            else
                put_text(CH_NUL, 1'b0);
        end
        else if (pick < 94)
            put_text(pick_stray_byte(), 1'b0);
        else
            put_text(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
    endtask

    // ---------------------------------------------------------------------
    // Token sink: random back-pressure, steady while calm
    // ---------------------------------------------------------------------
    initial
    begin : token_sink
        int left;
        left        = 0;
        token_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                token_ready = 1'b1;
            else if (left > 0)
                left--;
            else if (token_ready)
            begin
                token_ready = 1'b0;
                left        = pick_gap();
            end
            else
            begin
                token_ready = 1'b1;
                left        = $urandom_range(0, 10);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Token checker: compare each accepted word with the oldest expectation
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && token_valid && token_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: token with nothing expected, expected none, actual kind %0d start %0d",
                         $time, token_kind, token_start);
            end
            else
            begin
                want = tokens_due.pop_front();
                check_field("token_kind", 32'(want.kind), 32'(token_kind));
                check_field("token_start", want.start, token_start);
                check_field("token_length", 32'(want.length), 32'(token_length));
                check_field("length_saturated", 32'(want.saturated), 32'(length_saturated));
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                tokens_checked++;
                if (length_saturated)
                    saturated_seen++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin : main_seq
        token_t fixed_tok;
        int     live;
        int     guard;
        text_valid     = 1'b0;
        text_byte      = '0;
        end_of_text    = 1'b0;
        rst_n          = 1'b0;
        calm           = 1'b0;
        fail_count     = 0;
        words_sent     = 0;
        tokens_checked = 0;
        texts_closed   = 0;
        saturated_seen = 0;
        clear_scan();

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // opening text: extremes of the byte, keywords, operators, errors, ends
        foreach (OPENING_TEXT[i])
        begin
            fixed_tok = make_token(OPENING_TEXT[i].kind, OPENING_TEXT[i].start,
                                   17'(OPENING_TEXT[i].length));
            fixed_tok.last = 1'b1;
            put_word(OPENING_TEXT[i].ch, OPENING_TEXT[i].eot, OPENING_TEXT[i].fixed, fixed_tok);
        end
        drain_tokens();

        // long tokens at full rate: an identifier that starts like "te" and
        // runs on, then a long number closed by an operator
        calm = 1'b1;
        put_text(8'h74, 1'b0);
        put_text(8'h65, 1'b0);
        repeat (30) put_text(pick_word_char(1'b0), 1'b0);
        put_text(CH_NUL, 1'b1);
        put_text(8'h31, 1'b0);
        repeat (19) put_text(pick_number_char(), 1'b0);
        put_text(OP_CHARS[0], 1'b0);
        put_text(CH_NUL, 1'b0);
        drain_tokens();
        calm = 1'b0;

        // random lexemes; words swallowed after an error are not counted
        live = 0;
        while (live < 650)
        begin
            guard = words_sent;
            if (mode_q != MODE_HALT)
            begin
                send_lexeme();
                live += words_sent - guard;
            end
            else if ($urandom_range(0, 3) == 0)
                put_text(CH_NUL, 1'($urandom_range(0, 1)));
            else
                put_text(8'($urandom_range(0, 255)), 1'b0);
            if (live / 150 != (live - (words_sent - guard)) / 150)
            begin
                drain_tokens();
                calm = ($urandom_range(0, 3) == 0);
            end
        end
        put_text(CH_NUL, 1'b1);
        text_valid = 1'b0;
        calm       = 1'b0;

        // wait for the queue to empty, then keep watching for strays
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d text words over %0d texts; checked %0d tokens, %0d of them saturated.",
                 words_sent, texts_closed, tokens_checked, saturated_seen);
        if (fail_count == 0)
            $display("[keyword_token_scanner_unit] OK");
        else
            $display("[keyword_token_scanner_unit] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Timeout with %0d tokens still expected.", tokens_due.size());
        $display("[keyword_token_scanner_unit] ERROR");
        $finish;
    end

endmodule
